// ===== rtl/nmea_sentence_checker_defines.svh =====
// Shared assertion macros for the sentence checker.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// Condition holds at every clock edge
`define NSC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence holds in the same cycle as the antecedent
`define NSC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequence holds in the cycle after the antecedent
`define NSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nsc_pkg.sv =====
package nsc_pkg;

	// Default configuration
	localparam int MAX_FIELDS_DEF         = 24;
	localparam int MAX_SENTENCE_CHARS_DEF = 83;
	localparam logic [39:0] SENTENCE_ID_RESET = 40'h474E5A4441;

	// Fixed widths of the item fields
	localparam int BYTE_W  = 8;
	localparam int FIDX_W  = 5;
	localparam int POS_W   = 7;
	localparam int LEN_W   = 7;
	localparam int ID_W    = 40;
	localparam int ID_CHARS = 5;
	localparam int IDM_W   = 3;

	// Characters of interest
	localparam logic [7:0] CHR_DOLLAR = 8'd36;
	localparam logic [7:0] CHR_STAR   = 8'd42;
	localparam logic [7:0] CHR_COMMA  = 8'd44;
	localparam logic [7:0] CHR_CR     = 8'd13;
	localparam logic [7:0] CHR_LF     = 8'd10;
	localparam logic [7:0] CHR_0      = 8'd48;
	localparam logic [7:0] CHR_9      = 8'd57;
	localparam logic [7:0] CHR_A      = 8'd65;
	localparam logic [7:0] CHR_F      = 8'd70;
	localparam logic [7:0] HEX_ALPHA_OFS = 8'd7;

	// Result kinds
	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict codes
	localparam logic [1:0] V_OK        = 2'd0;
	localparam logic [1:0] V_MISMATCH  = 2'd1;
	localparam logic [1:0] V_MALFORMED = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ID,
		PH_BODY,
		PH_HEX1,
		PH_HEX2
	} phase_t;

	typedef struct packed {
		logic              result_kind;
		logic [FIDX_W-1:0] field_index;
		logic [POS_W-1:0]  char_in_field;
		logic [BYTE_W-1:0] char_value;
		logic [1:0]        verdict;
		logic [FIDX_W-1:0] field_count;
		logic              is_last;
	} result_t;

	// Uppercase hex digit decode: {ok, nibble}
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CHR_0 && c <= CHR_9) begin
			v = c - CHR_0;
			return {1'b1, v[3:0]};
		end
		if (c >= CHR_A && c <= CHR_F) begin
			v = c - CHR_0 - HEX_ALPHA_OFS;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

// ===== rtl/nmea_sentence_checker.sv =====
// Channel   Handshake                 Payload
// input     in_valid / in_ready       rx_byte
// result    out_valid / out_ready     result_kind, field_index, char_in_field,
//                                     char_value, verdict, field_count, is_last
// config    sentence_id_we            sentence_id
//
// One byte is accepted per cycle while in_ready is high; its result, if any, passes from
// the input register into the result register, which holds it until out_ready takes it.
// The rate is set by the input register feeding one pass of compare/XOR logic.
// A stalled result register holds; the input register takes a new byte only
// when it is empty or the result register can move.
// arst_n clears all control state and loads the default identifier "GNZDA".
`include "nmea_sentence_checker_defines.svh"

module nmea_sentence_checker #(
	parameter int MAX_FIELDS         = nsc_pkg::MAX_FIELDS_DEF,
	parameter int MAX_SENTENCE_CHARS = nsc_pkg::MAX_SENTENCE_CHARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sentence_id_we,
	input  logic [nsc_pkg::ID_W-1:0]     sentence_id,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [nsc_pkg::BYTE_W-1:0]   rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         result_kind,
	output logic [nsc_pkg::FIDX_W-1:0]   field_index,
	output logic [nsc_pkg::POS_W-1:0]    char_in_field,
	output logic [nsc_pkg::BYTE_W-1:0]   char_value,
	output logic [1:0]                   verdict,
	output logic [nsc_pkg::FIDX_W-1:0]   field_count,
	output logic                         is_last
);

	logic                        valid_s1;
	logic [nsc_pkg::BYTE_W-1:0]  rx_s1;
	logic                        out_valid_s2;
	nsc_pkg::result_t            res_s2;
	logic                        advance, step, res_valid;
	nsc_pkg::result_t            res;

	// Move the pipeline when the result register is empty or being taken
	assign advance  = !out_valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	nsc_parser #(
		.MAX_FIELDS         (MAX_FIELDS),
		.MAX_SENTENCE_CHARS (MAX_SENTENCE_CHARS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (sentence_id_we),
		.cfg_data  (sentence_id),
		.step      (step),
		.rx        (rx_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = out_valid_s2;
	assign result_kind   = res_s2.result_kind;
	assign field_index   = res_s2.field_index;
	assign char_in_field = res_s2.char_in_field;
	assign char_value    = res_s2.char_value;
	assign verdict       = res_s2.verdict;
	assign field_count   = res_s2.field_count;
	assign is_last       = res_s2.is_last;

	`NSC_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1 && $stable(rx_s1), "input stage lost a stalled item")
	`NSC_ASSERT_IMPLIES(a_verdict_fmt, out_valid_s2 && res_s2.result_kind == nsc_pkg::KIND_VERDICT, res_s2.is_last && res_s2.verdict != 2'd3, "bad verdict result")
	`NSC_ASSERT_IMPLIES(a_char_fmt, out_valid_s2 && res_s2.result_kind == nsc_pkg::KIND_CHAR, !res_s2.is_last && res_s2.verdict == nsc_pkg::V_OK && res_s2.field_count == '0, "bad character result")

endmodule

// ===== rtl/nsc_parser.sv =====
`include "nmea_sentence_checker_defines.svh"

module nsc_parser #(
	parameter int MAX_FIELDS         = nsc_pkg::MAX_FIELDS_DEF,
	parameter int MAX_SENTENCE_CHARS = nsc_pkg::MAX_SENTENCE_CHARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [nsc_pkg::ID_W-1:0]     cfg_data,
	input  logic                         step,
	input  logic [nsc_pkg::BYTE_W-1:0]   rx,
	output logic                         res_valid,
	output nsc_pkg::result_t             res
);

	localparam int FW = $clog2(MAX_FIELDS + 1);
	localparam logic [FW-1:0] FIELD_LIMIT = FW'(MAX_FIELDS);
	localparam logic [nsc_pkg::LEN_W-1:0] LEN_LIMIT = nsc_pkg::LEN_W'(MAX_SENTENCE_CHARS);

	logic [nsc_pkg::ID_W-1:0]   sentence_id_q;
	nsc_pkg::phase_t            phase_q, phase_d;
	logic [nsc_pkg::IDM_W-1:0]  id_matched_q, id_matched_d;
	logic [7:0]                 xor_q, xor_d;
	logic [3:0]                 nibble_q, nibble_d;
	logic [nsc_pkg::LEN_W-1:0]  len_q, len_d;
	logic [FW-1:0]              field_q, field_d;
	logic [nsc_pkg::POS_W-1:0]  pos_q, pos_d;

	logic [7:0] want;
	logic [4:0] hex;
	logic       is_dollar, is_star, is_comma, is_eol, id_ok, too_long, room;
	logic [FW:0] count_wide;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentence_id_q <= nsc_pkg::SENTENCE_ID_RESET;
		end else if (cfg_we) begin
			sentence_id_q <= cfg_data;
		end
	end

	// Pick the identifier character expected next
	always_comb begin
		case (id_matched_q)
			3'd0:    want = sentence_id_q[39:32];
			3'd1:    want = sentence_id_q[31:24];
			3'd2:    want = sentence_id_q[23:16];
			3'd3:    want = sentence_id_q[15:8];
			3'd4:    want = sentence_id_q[7:0];
			default: want = sentence_id_q[39:32];
		endcase
	end

	// Byte classification
	assign is_dollar = (rx == nsc_pkg::CHR_DOLLAR);
	assign is_star   = (rx == nsc_pkg::CHR_STAR);
	assign is_comma  = (rx == nsc_pkg::CHR_COMMA);
	assign is_eol    = (rx == nsc_pkg::CHR_CR) || (rx == nsc_pkg::CHR_LF);
	assign id_ok     = (rx == want);
	assign too_long  = (len_q >= LEN_LIMIT);
	assign room      = (field_q < FIELD_LIMIT);
	assign hex       = nsc_pkg::hex_digit(rx);
	assign count_wide = (field_q == FIELD_LIMIT) ? {1'b0, FIELD_LIMIT}
		: {1'b0, field_q} + (FW+1)'(1);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (is_dollar) begin
			phase_d = nsc_pkg::PH_ID;
		end else begin
			case (phase_q)
				nsc_pkg::PH_ID: begin
					if (!id_ok) begin
						phase_d = nsc_pkg::PH_HUNT;
					end else if (id_matched_q == 3'(nsc_pkg::ID_CHARS - 1)) begin
						phase_d = nsc_pkg::PH_BODY;
					end
				end
				nsc_pkg::PH_BODY: begin
					if (is_star) begin
						phase_d = nsc_pkg::PH_HEX1;
					end else if (is_eol || too_long) begin
						phase_d = nsc_pkg::PH_HUNT;
					end
				end
				nsc_pkg::PH_HEX1: begin
					phase_d = hex[4] ? nsc_pkg::PH_HEX2 : nsc_pkg::PH_HUNT;
				end
				nsc_pkg::PH_HEX2: phase_d = nsc_pkg::PH_HUNT;
				default: phase_d = nsc_pkg::PH_HUNT;
			endcase
		end
	end

	// Datapath updates and result
	always_comb begin
		id_matched_d = id_matched_q;
		xor_d        = xor_q;
		nibble_d     = nibble_q;
		len_d        = len_q;
		field_d      = field_q;
		pos_d        = pos_q;
		res_valid    = 1'b0;
		res          = '0;
		if (is_dollar) begin
			id_matched_d = '0;
			xor_d        = '0;
			nibble_d     = '0;
			len_d        = '0;
			field_d      = '0;
			pos_d        = '0;
		end else begin
			case (phase_q)
				nsc_pkg::PH_ID: begin
					if (id_ok) begin
						xor_d             = xor_q ^ rx;
						len_d             = len_q + 1'b1;
						pos_d             = pos_q + 1'b1;
						id_matched_d      = id_matched_q + 1'b1;
						res_valid         = 1'b1;
						res.result_kind   = nsc_pkg::KIND_CHAR;
						res.field_index   = nsc_pkg::FIDX_W'(field_q);
						res.char_in_field = pos_q;
						res.char_value    = rx;
					end
				end
				nsc_pkg::PH_BODY: begin
					if (is_star) begin
						res_valid = 1'b0;
					end else if (is_eol || too_long) begin
						res_valid       = 1'b1;
						res.result_kind = nsc_pkg::KIND_VERDICT;
						res.verdict     = nsc_pkg::V_MALFORMED;
						res.field_count = nsc_pkg::FIDX_W'(count_wide);
						res.is_last     = 1'b1;
					end else begin
						len_d = len_q + 1'b1;
						xor_d = xor_q ^ rx;
						if (is_comma) begin
							if (room) begin
								field_d = field_q + 1'b1;
							end
							pos_d = '0;
						end else if (room) begin
							pos_d             = pos_q + 1'b1;
							res_valid         = 1'b1;
							res.result_kind   = nsc_pkg::KIND_CHAR;
							res.field_index   = nsc_pkg::FIDX_W'(field_q);
							res.char_in_field = pos_q;
							res.char_value    = rx;
						end
					end
				end
				nsc_pkg::PH_HEX1: begin
					if (hex[4]) begin
						nibble_d = hex[3:0];
					end else begin
						res_valid       = 1'b1;
						res.result_kind = nsc_pkg::KIND_VERDICT;
						res.verdict     = nsc_pkg::V_MALFORMED;
						res.field_count = nsc_pkg::FIDX_W'(count_wide);
						res.is_last     = 1'b1;
					end
				end
				nsc_pkg::PH_HEX2: begin
					res_valid       = 1'b1;
					res.result_kind = nsc_pkg::KIND_VERDICT;
					res.field_count = nsc_pkg::FIDX_W'(count_wide);
					res.is_last     = 1'b1;
					if (!hex[4]) begin
						res.verdict = nsc_pkg::V_MALFORMED;
					end else if ({nibble_q, hex[3:0]} == xor_q) begin
						res.verdict = nsc_pkg::V_OK;
					end else begin
						res.verdict = nsc_pkg::V_MISMATCH;
					end
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	// Advance the parser state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= nsc_pkg::PH_HUNT;
			id_matched_q <= '0;
			xor_q        <= '0;
			nibble_q     <= '0;
			len_q        <= '0;
			field_q      <= '0;
			pos_q        <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			id_matched_q <= id_matched_d;
			xor_q        <= xor_d;
			nibble_q     <= nibble_d;
			len_q        <= len_d;
			field_q      <= field_d;
			pos_q        <= pos_d;
		end
	end

	`NSC_ASSERT_IMPLIES(a_id_count, phase_q == nsc_pkg::PH_ID, id_matched_q < 3'(nsc_pkg::ID_CHARS), "identifier count out of range")
	`NSC_ASSERT_ALWAYS(a_field_limit, field_q <= FIELD_LIMIT, "field counter beyond limit")
	`NSC_ASSERT_IMPLIES(a_verdict_hunt, res_valid && res.result_kind == nsc_pkg::KIND_VERDICT, phase_d == nsc_pkg::PH_HUNT, "verdict without return to hunt")

endmodule

// ===== sim/tb_nmea_sentence_checker.sv =====
`timescale 1ns / 100ps

module tb_nmea_sentence_checker;
	import nsc_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 6;
	localparam int IDLE_PCT     = 19;
	localparam int STEADY_FROM  = 700;
	localparam int STEADY_TO    = 1300;
	localparam int RANDOM_BYTES = 265;

	typedef enum int {
		SK_GOOD,
		SK_BAD_SUM,
		SK_BAD_HEX_HI,
		SK_BAD_HEX_LO,
		SK_EARLY_EOL,
		SK_BAD_ID,
		SK_CUT
	} sent_kind_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              sentence_id_we = 1'b0;
	logic [ID_W-1:0]   sentence_id    = SENTENCE_ID_RESET;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] rx_byte        = '0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic              result_kind;
	logic [FIDX_W-1:0] field_index;
	logic [POS_W-1:0]  char_in_field;
	logic [BYTE_W-1:0] char_value;
	logic [1:0]        verdict;
	logic [FIDX_W-1:0] field_count;
	logic              is_last;

	nmea_sentence_checker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.sentence_id_we(sentence_id_we),
		.sentence_id   (sentence_id),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.field_index   (field_index),
		.char_in_field (char_in_field),
		.char_value    (char_value),
		.verdict       (verdict),
		.field_count   (field_count),
		.is_last       (is_last)
	);

	// Parser shadow state
	logic [ID_W-1:0]   cur_id    = SENTENCE_ID_RESET;
	phase_t            ph        = PH_HUNT;
	logic [2:0]        id_cnt    = '0;
	logic [7:0]        run_xor   = '0;
	logic [3:0]        hi_nib    = '0;
	logic [6:0]        sent_len  = '0;
	logic [FIDX_W-1:0] cur_field = '0;
	logic [POS_W-1:0]  pos_field = '0;

	result_t           expected_results[$];
	logic [7:0]        pending_bytes[$];
	result_t           observed;
	result_t           predicted;
	logic              in_taken      = 1'b0;
	int                bytes_queued  = 0;
	int                bytes_taken   = 0;
	int                cycle_count   = 0;
	int                quiet_cycles  = 0;
	int                errors        = 0;
	int                chars_checked = 0;
	int                verdict_seen[3] = '{0, 0, 0};
	int                id_writes     = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int digit_value(input logic [7:0] c);
		if (c >= CHR_0 && c <= CHR_9) return c - CHR_0;
		if (c >= CHR_A && c <= CHR_F) return c - CHR_A + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'(CHR_0 + n) : 8'(CHR_A + n - 8'd10);
	endfunction

	function automatic bit idle_now();
		if (cycle_count >= STEADY_FROM && cycle_count < STEADY_TO) return 1'b0;
		return $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf(
			"kind=%0d fidx=%0d pos=%0d chr=%02h verdict=%0d count=%0d last=%0d",
			r.result_kind, r.field_index, r.char_in_field, r.char_value, r.verdict,
			r.field_count, r.is_last);
	endfunction

	task automatic log_error(input string msg);
		errors++;
		if (errors <= 10) $display("ERROR: %s", msg);
	endtask

	// Expected results of the parser
	task automatic push_char(input logic [7:0] c);
		result_t r;
		r = '0;
		r.result_kind   = KIND_CHAR;
		r.field_index   = cur_field;
		r.char_in_field = pos_field;
		r.char_value    = c;
		expected_results.push_back(r);
		pos_field++;
	endtask

	task automatic push_verdict(input logic [1:0] v);
		result_t r;
		int      cnt;
		r = '0;
		cnt = cur_field + 1;
		if (cnt > MAX_FIELDS_DEF) cnt = MAX_FIELDS_DEF;
		r.result_kind = KIND_VERDICT;
		r.verdict     = v;
		r.field_count = cnt[FIDX_W-1:0];
		r.is_last     = 1'b1;
		expected_results.push_back(r);
		ph = PH_HUNT;
	endtask

	task automatic predict_byte(input logic [7:0] c);
		int nib;
		// '$' restarts from any phase
		if (c == CHR_DOLLAR) begin
			ph        = PH_ID;
			id_cnt    = '0;
			run_xor   = '0;
			hi_nib    = '0;
			sent_len  = '0;
			cur_field = '0;
			pos_field = '0;
			return;
		end
		case (ph)
			PH_ID: begin
				if (c != cur_id[8 * (ID_CHARS - 1 - id_cnt) +: 8]) begin
					ph = PH_HUNT;
				end else begin
					run_xor ^= c;
					sent_len++;
					push_char(c);
					id_cnt++;
					if (id_cnt >= ID_CHARS) ph = PH_BODY;
				end
			end
			PH_BODY: begin
				if (c == CHR_STAR) begin
					ph = PH_HEX1;
				end else if (c == CHR_CR || c == CHR_LF) begin
					push_verdict(V_MALFORMED);
				end else if (sent_len + 1 > MAX_SENTENCE_CHARS_DEF) begin
					push_verdict(V_MALFORMED);
				end else begin
					sent_len++;
					run_xor ^= c;
					if (c == CHR_COMMA) begin
						if (cur_field < MAX_FIELDS_DEF) cur_field++;
						pos_field = '0;
					end else if (cur_field < MAX_FIELDS_DEF) begin
						push_char(c);
					end
				end
			end
			PH_HEX1: begin
				nib = digit_value(c);
				if (nib < 0) begin
					push_verdict(V_MALFORMED);
				end else begin
					hi_nib = nib[3:0];
					ph = PH_HEX2;
				end
			end
			PH_HEX2: begin
				nib = digit_value(c);
				if (nib < 0) push_verdict(V_MALFORMED);
				else if ({hi_nib, nib[3:0]} == run_xor) push_verdict(V_OK);
				else push_verdict(V_MISMATCH);
			end
			default: ;
		endcase
	endtask

	// Stimulus building
	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_noise(input int n);
		repeat (n) queue_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do begin
			c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(32, 126));
		end while (c == CHR_DOLLAR || c == CHR_STAR || c == CHR_COMMA ||
			c == CHR_CR || c == CHR_LF);
		return c;
	endfunction

	function automatic logic [7:0] bad_digit();
		logic [7:0] c;
		logic [7:0] near_hex[6];
		// just outside the digit ranges, and lowercase letters
		near_hex = '{CHR_0 - 8'd1, CHR_9 + 8'd1, CHR_A - 8'd1, CHR_F + 8'd1,
			CHR_A + 8'd32, CHR_F + 8'd32};
		if ($urandom_range(0, 1)) return near_hex[$urandom_range(0, 5)];
		do begin
			c = 8'($urandom_range(0, 255));
		end while (digit_value(c) >= 0 || c == CHR_DOLLAR);
		return c;
	endfunction

	task automatic queue_sentence(input sent_kind_t kind, input int nfields, input int maxc,
		input bit fixed_len);
		logic [7:0] sum;
		logic [7:0] c;
		int         bad_at;
		int         eol_at;
		int         stop;
		int         nchar;
		int         f;
		int         k;
		sum    = '0;
		bad_at = $urandom_range(0, ID_CHARS - 1);
		eol_at = $urandom_range(0, nfields - 1);
		stop   = $urandom_range(0, 3);
		queue_byte(CHR_DOLLAR);
		for (k = 0; k < ID_CHARS; k++) begin
			c = cur_id[8 * (ID_CHARS - 1 - k) +: 8];
			if (kind == SK_BAD_ID && k == bad_at) c ^= 8'd1 << $urandom_range(0, 7);
			sum ^= c;
			queue_byte(c);
		end
		for (f = 0; f < nfields; f++) begin
			if (f > 0) begin
				queue_byte(CHR_COMMA);
				sum ^= CHR_COMMA;
				nchar = fixed_len ? maxc : $urandom_range(0, maxc);
				for (k = 0; k < nchar; k++) begin
					c = body_char();
					sum ^= c;
					queue_byte(c);
				end
			end
			if (kind == SK_EARLY_EOL && f == eol_at) begin
				queue_byte($urandom_range(0, 1) ? CHR_CR : CHR_LF);
				return;
			end
		end
		// a cut sentence is dropped by the '$' of whatever follows it
		if (kind == SK_CUT && stop < 2) return;
		queue_byte(CHR_STAR);
		if (kind == SK_CUT) begin
			if (stop == 3) queue_byte(hex_char(sum[7:4]));
			return;
		end
		if (kind == SK_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
		queue_byte(kind == SK_BAD_HEX_HI ? bad_digit() : hex_char(sum[7:4]));
		queue_byte(kind == SK_BAD_HEX_LO ? bad_digit() : hex_char(sum[3:0]));
		queue_byte(CHR_CR);
		queue_byte(CHR_LF);
	endtask

	task automatic queue_random_sentence();
		int pick;
		int nf;
		int mc;
		pick = $urandom_range(0, 99);
		nf   = $urandom_range(1, 10);
		mc   = $urandom_range(0, 6);
		// now and then run past the field limit with short fields
		if ($urandom_range(0, 9) == 0) begin
			nf = $urandom_range(20, 30);
			mc = $urandom_range(0, 2);
		end
		if (pick < 55) queue_sentence(SK_GOOD, nf, mc, 1'b0);
		else if (pick < 63) queue_sentence(SK_BAD_SUM, nf, mc, 1'b0);
		else if (pick < 68) queue_sentence(SK_BAD_HEX_HI, nf, mc, 1'b0);
		else if (pick < 73) queue_sentence(SK_BAD_HEX_LO, nf, mc, 1'b0);
		else if (pick < 79) queue_sentence(SK_EARLY_EOL, nf, mc, 1'b0);
		else if (pick < 85) queue_sentence(SK_BAD_ID, nf, mc, 1'b0);
		else if (pick < 91) queue_sentence(SK_CUT, nf, mc, 1'b0);
		else if (pick < 95) queue_noise($urandom_range(1, 8));
		else queue_sentence(SK_GOOD, $urandom_range(9, 12), $urandom_range(10, 14), 1'b1);
	endtask

	// Hold until every byte is taken and every result is back, then let the pipe empty
	task automatic wait_idle();
		while (bytes_taken != bytes_queued || expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_sentence_id(input logic [ID_W-1:0] value);
		sentence_id    <= value;
		sentence_id_we <= 1'b1;
		cur_id = value;
		id_writes++;
		@(negedge clk);
		sentence_id_we <= 1'b0;
	endtask

	// Input driver and result-side stalls
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_bytes.size() != 0 && !idle_now()) begin
				rx_byte  <= pending_bytes.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= !idle_now();
	end

	// Predict on accepted bytes, check accepted results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			quiet_cycles++;
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				predict_byte(rx_byte);
				bytes_taken++;
				quiet_cycles = 0;
			end
			if (out_valid && out_ready) begin
				quiet_cycles = 0;
				observed = {result_kind, field_index, char_in_field, char_value, verdict,
					field_count, is_last};
				if (expected_results.size() == 0) begin
					log_error($sformatf("unexpected result %s", describe(observed)));
				end else begin
					predicted = expected_results.pop_front();
					if (observed !== predicted)
						log_error($sformatf("expected %s, got %s", describe(predicted),
							describe(observed)));
					else if (observed.result_kind == KIND_VERDICT)
						verdict_seen[observed.verdict]++;
					else
						chars_checked++;
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [ID_W-1:0] rand_id;
		logic [7:0]      c;
		logic [ID_W-1:0] id_list[4];
		int              target;
		int              p;
		int              k;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: default identifier
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h80);
		queue_byte(8'h7F);
		queue_sentence(SK_GOOD, 1, 0, 1'b1);
		queue_sentence(SK_GOOD, 6, 3, 1'b0);
		queue_sentence(SK_BAD_SUM, 4, 2, 1'b0);
		queue_sentence(SK_BAD_HEX_HI, 2, 2, 1'b0);
		queue_sentence(SK_BAD_HEX_LO, 2, 2, 1'b0);
		queue_sentence(SK_EARLY_EOL, 3, 2, 1'b0);
		queue_sentence(SK_EARLY_EOL, 1, 0, 1'b0);
		// exactly at the length limit, then one character over
		queue_sentence(SK_GOOD, 2, 77, 1'b1);
		queue_sentence(SK_GOOD, 2, 78, 1'b1);
		// at, one past, and well past the field limit
		queue_sentence(SK_GOOD, 24, 1, 1'b1);
		queue_sentence(SK_GOOD, 25, 1, 1'b1);
		queue_sentence(SK_GOOD, 28, 1, 1'b1);
		queue_sentence(SK_BAD_ID, 3, 2, 1'b0);
		queue_sentence(SK_CUT, 4, 3, 1'b0);
		queue_sentence(SK_GOOD, 3, 2, 1'b0);
		wait_idle();

		// Identifier holding '$': restart wins, nothing should match
		write_sentence_id({"GP", CHR_DOLLAR, "GA"});
		queue_sentence(SK_GOOD, 3, 2, 1'b0);
		queue_sentence(SK_GOOD, 2, 1, 1'b0);
		wait_idle();

		// Random sentences under several identifiers, extremes first
		for (k = 0; k < ID_CHARS; k++) begin
			c = 8'($urandom_range(0, 255));
			if (c == CHR_DOLLAR) c = c + 8'd1;
			rand_id[8 * k +: 8] = c;
		end
		id_list = '{40'h0, {ID_W{1'b1}}, rand_id, "GPGGA"};
		for (p = 0; p < 4; p++) begin
			write_sentence_id(id_list[p]);
			target = bytes_queued + RANDOM_BYTES;
			while (bytes_queued < target) queue_random_sentence();
			wait_idle();
		end

		errors += expected_results.size();
		$display("Checked %0d field characters and %0d verdicts",
			chars_checked, verdict_seen[0] + verdict_seen[1] + verdict_seen[2]);
		$display("(%0d ok, %0d mismatch, %0d malformed) from %0d bytes under %0d identifiers",
			verdict_seen[0], verdict_seen[1], verdict_seen[2], bytes_taken, id_writes + 1);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/nsc_pkg.sv
rtl/nsc_parser.sv
rtl/nmea_sentence_checker.sv
sim/tb_nmea_sentence_checker.sv
